@@ hdl/fpsc_pkg.sv @@
// Package for the frustum point / sphere cull core.
// Plane record, register indexes, test masks and pipeline enable struct.
// No dependencies.
`timescale 1ns / 1ps

package fpsc_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int NUM_PLANES     = 6;
	localparam int COEF_W         = 16;
	localparam int COEF_SHIFT     = 14;
	localparam int PLANE_W        = 64;
	localparam int CFG_IDX_W      = 3;
	localparam int RADIUS_W       = 15;
	localparam int MARGIN_W       = 16;

	localparam logic [CFG_IDX_W-1:0] REG_PLANE_NEAR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_FAR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_LEFT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_TOP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PLANE_BOTTOM = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MARGIN       = 3'd6;

	localparam logic signed [MARGIN_W-1:0] MARGIN_RESET = 16'sd80;

	localparam logic CMD_POINT  = 1'b0;
	localparam logic CMD_SPHERE = 1'b1;

	// bit i = plane i (near, far, right, left, top, bottom)
	localparam logic [NUM_PLANES-1:0] POINT_MASK  = 6'b111101; // all but far
	localparam logic [NUM_PLANES-1:0] SPHERE_MASK = 6'b111110; // all but near

	typedef struct packed {
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] a;
	} plane_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

endpackage

@@ hdl/fpsc_cfg_regs.sv @@
// Configuration register file: six frustum planes and the point margin.
// Uses fpsc_pkg.
`timescale 1ns / 1ps

module fpsc_cfg_regs (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    wr_en,
	input  logic [fpsc_pkg::CFG_IDX_W-1:0]          wr_index,
	input  logic [fpsc_pkg::PLANE_W-1:0]            wr_data,
	output fpsc_pkg::plane_t                        planes [fpsc_pkg::NUM_PLANES],
	output logic signed [fpsc_pkg::MARGIN_W-1:0]    margin
);

	fpsc_pkg::plane_t                        planes_q [fpsc_pkg::NUM_PLANES];
	logic signed [fpsc_pkg::MARGIN_W-1:0]    margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fpsc_pkg::NUM_PLANES; i++) begin
				planes_q[i] <= '0;
			end
			margin_q <= fpsc_pkg::MARGIN_RESET;
		end else if (wr_en) begin
			case (wr_index)
				fpsc_pkg::REG_MARGIN: begin
					margin_q <= wr_data[fpsc_pkg::MARGIN_W-1:0];
				end
				default: begin
					if (wr_index <= fpsc_pkg::REG_PLANE_BOTTOM) begin
						planes_q[wr_index] <= wr_data;
					end
				end
			endcase
		end
	end

	assign planes = planes_q;
	assign margin = margin_q;

endmodule

@@ hdl/fpsc_plane_lane.sv @@
// One plane's distance pipeline: products, partial sums, sum and compare.
// Uses fpsc_pkg. Three register stages, enabled by the top level's flow control.
`timescale 1ns / 1ps

module fpsc_plane_lane #(
	parameter int COORD_BITS = fpsc_pkg::COORD_BITS_DEF,
	parameter int DW         = 34
) (
	input  logic                         clk,
	input  fpsc_pkg::stage_en_t          en,
	input  fpsc_pkg::plane_t             plane,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic signed [DW-1:0]         limit_s2,
	output logic                         fail_s3
);

	localparam int PW = COORD_BITS + fpsc_pkg::COEF_W;

	logic signed [PW-1:0] ax_s1, by_s1, cz_s1;
	logic signed [DW-1:0] ab_s2, cd_s2;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			ax_s1 <= PW'(plane.a) * PW'(pos_x);
			by_s1 <= PW'(plane.b) * PW'(pos_y);
			cz_s1 <= PW'(plane.c) * PW'(pos_z);
		end
		if (en.s2) begin
			ab_s2 <= DW'(ax_s1) + DW'(by_s1);
			cd_s2 <= DW'(cz_s1) + (DW'(plane.d) <<< fpsc_pkg::COEF_SHIFT);
		end
		if (en.s3) begin
			fail_s3 <= (ab_s2 + cd_s2) > limit_s2;
		end
	end

endmodule

@@ hdl/frustum_point_sphere_cull_core.sv @@
// Top level of the frustum point / sphere cull core.
// Uses fpsc_pkg, fpsc_cfg_regs and six fpsc_plane_lane instances.
//
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata pos_x,pos_y,pos_z,radius; tuser cmd
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata inside_res
// cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; stages: products, partial sums, compare, output.
// All six plane lanes run in parallel; each stage holds while the next is full and cannot advance.
// Empty stages fill while the output is stalled, so nothing is lost or repeated.
// Reset clears the stage valid bits and loads the register reset values.
// cfg_ready is always high; write only while the pipeline is empty.
`timescale 1ns / 1ps

module frustum_point_sphere_cull_core #(
	parameter int COORD_BITS = fpsc_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// pos_x, pos_y, pos_z, sphere_radius, zero pad
	input  logic [((3*COORD_BITS+fpsc_pkg::RADIUS_W+7)/8)*8-1:0] s_axis_tdata,
	// cmd
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// inside_res, zero pad
	output logic [7:0]                          m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fpsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpsc_pkg::PLANE_W-1:0]        cfg_data
);

	localparam int DW = (COORD_BITS + 18 > 32) ? COORD_BITS + 18 : 32;

	fpsc_pkg::plane_t                     planes [fpsc_pkg::NUM_PLANES];
	logic signed [fpsc_pkg::MARGIN_W-1:0] margin;

	logic signed [COORD_BITS-1:0]         pos_x, pos_y, pos_z;
	logic [fpsc_pkg::RADIUS_W-1:0]        radius;
	logic signed [fpsc_pkg::MARGIN_W-1:0] limit_sel;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic cmd_s1, cmd_s2, cmd_s3;
	logic signed [DW-1:0] limit_s1, limit_s2;
	logic [fpsc_pkg::NUM_PLANES-1:0] fail_s3;
	logic inside_s4;
	fpsc_pkg::stage_en_t en;

	assign cfg_ready = 1'b1;

	fpsc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.planes   (planes),
		.margin   (margin)
	);

	assign pos_x  = s_axis_tdata[COORD_BITS-1:0];
	assign pos_y  = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
	assign pos_z  = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign radius = s_axis_tdata[3*COORD_BITS+fpsc_pkg::RADIUS_W-1:3*COORD_BITS];

	assign limit_sel = (s_axis_tuser == fpsc_pkg::CMD_SPHERE) ?
		$signed({1'b0, radius}) : margin;

	assign rdy4 = !v_s4 || m_axis_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;

	assign en.s1 = rdy1;
	assign en.s2 = rdy2;
	assign en.s3 = rdy3;

	for (genvar p = 0; p < fpsc_pkg::NUM_PLANES; p++) begin : g_lane
		fpsc_plane_lane #(
			.COORD_BITS (COORD_BITS),
			.DW         (DW)
		) u_lane (
			.clk      (clk),
			.en       (en),
			.plane    (planes[p]),
			.pos_x    (pos_x),
			.pos_y    (pos_y),
			.pos_z    (pos_z),
			.limit_s2 (limit_s2),
			.fail_s3  (fail_s3[p])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			cmd_s1   <= s_axis_tuser;
			limit_s1 <= DW'(limit_sel) <<< fpsc_pkg::COEF_SHIFT;
		end
		if (rdy2) begin
			cmd_s2   <= cmd_s1;
			limit_s2 <= limit_s1;
		end
		if (rdy3) begin
			cmd_s3 <= cmd_s2;
		end
		if (rdy4) begin
			inside_s4 <= ~|(fail_s3 & ((cmd_s3 == fpsc_pkg::CMD_SPHERE) ?
				fpsc_pkg::SPHERE_MASK : fpsc_pkg::POINT_MASK));
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {7'b0, inside_s4};

endmodule

@@ hdl/fpsc_checker.sv @@
// Port-level checks for the frustum point / sphere cull core, bound to the top.
// Depends on frustum_point_sphere_cull_core port names.
`timescale 1ns / 1ps

module fpsc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready
);

	// stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// free output means the whole pipe can move
	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tready || !m_axis_tvalid) |-> s_axis_tready)
		else $error("input blocked with free output");

	// fixed latency when the output never stalls
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
		##1 m_axis_tready |=> m_axis_tvalid)
		else $error("item did not reach output in four cycles");

endmodule

bind frustum_point_sphere_cull_core fpsc_checker u_fpsc_checker (.*);

@@ tb/sv/testbench.sv @@
// Self-checking testbench for frustum_point_sphere_cull_core.
// Uses fpsc_pkg. A table of directed queries and register writes runs first,
// then random queries under several plane settings and ready/valid idle mixes.
`timescale 1ns / 1ps

module testbench;

	localparam int TDATA_W   = ((3*fpsc_pkg::COORD_BITS_DEF + fpsc_pkg::RADIUS_W + 7)/8)*8;
	localparam int LATENCY   = 4;
	localparam int SETTLE    = LATENCY + 2;
	localparam int MAX_CYCLES = 400000;
	localparam int BLOCKS    = 4;
	localparam int BLOCK_LEN = 161;

	localparam logic [fpsc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum bit {ROW_CFG, ROW_QUERY} row_kind_t;

	typedef struct {
		row_kind_t                           kind;
		logic [fpsc_pkg::CFG_IDX_W-1:0]      idx;
		logic [fpsc_pkg::PLANE_W-1:0]        data;
		logic                                cmd;
		logic signed [15:0]                  x, y, z;
		logic [fpsc_pkg::RADIUS_W-1:0]       r;
		bit                                  known;
		bit                                  want;
	} row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [TDATA_W-1:0]  s_axis_tdata = '0;
	logic                s_axis_tuser = 1'b0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [7:0]          m_axis_tdata;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [fpsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [fpsc_pkg::PLANE_W-1:0]  cfg_data = '0;

	fpsc_pkg::plane_t    plane_regs [fpsc_pkg::NUM_PLANES];
	logic signed [fpsc_pkg::MARGIN_W-1:0] margin_reg = fpsc_pkg::MARGIN_RESET;
	bit                  inside_due [$];
	row_t                steps [$];
	int                  errors = 0;
	int                  src_idle_pct = 15;
	int                  snk_idle_pct = 46;
	int                  cycles = 0;

	frustum_point_sphere_cull_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("ERROR @%0t: %s", $time, what);
		errors++;
	endtask

	// inside flag for one query against the current plane registers
	function automatic bit predict_inside(logic cmd, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z,
			logic [fpsc_pkg::RADIUS_W-1:0] r);
		logic [fpsc_pkg::NUM_PLANES-1:0] tested;
		longint bound;
		longint dist_v;
		bit in_flag;
		tested = (cmd == fpsc_pkg::CMD_SPHERE) ? fpsc_pkg::SPHERE_MASK : fpsc_pkg::POINT_MASK;
		bound = (cmd == fpsc_pkg::CMD_SPHERE) ? longint'({1'b0, r}) : longint'(margin_reg);
		bound = bound <<< fpsc_pkg::COEF_SHIFT;
		in_flag = 1'b1;
		for (int i = 0; i < fpsc_pkg::NUM_PLANES; i++) begin
			if (tested[i]) begin
				dist_v = longint'($signed(plane_regs[i].a)) * longint'(x)
					+ longint'($signed(plane_regs[i].b)) * longint'(y)
					+ longint'($signed(plane_regs[i].c)) * longint'(z)
					+ (longint'($signed(plane_regs[i].d)) <<< fpsc_pkg::COEF_SHIFT);
				if (dist_v > bound)
					in_flag = 1'b0;
			end
		end
		return in_flag;
	endfunction

	function automatic row_t cfg_row(logic [fpsc_pkg::CFG_IDX_W-1:0] idx,
			logic [fpsc_pkg::PLANE_W-1:0] data);
		row_t row;
		row = '{kind: ROW_CFG, default: '0};
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	function automatic row_t query_row(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic [fpsc_pkg::RADIUS_W-1:0] r, bit known, bit want);
		row_t row;
		row = '{kind: ROW_QUERY, default: '0};
		row.cmd = cmd;
		row.x = x;
		row.y = y;
		row.z = z;
		row.r = r;
		row.known = known;
		row.want = want;
		return row;
	endfunction

	function automatic logic signed [15:0] rand_coord();
		if ($urandom_range(0, 1))
			return 16'($urandom);
		return 16'(int'($urandom_range(0, 511)) - 256);
	endfunction

	function automatic logic [fpsc_pkg::PLANE_W-1:0] rand_plane();
		fpsc_pkg::plane_t p;
		case ($urandom_range(0, 3))
			0: p = '0;
			1: p = {$urandom, $urandom};
			2: begin
				p.a = 16'(int'($urandom_range(0, 4095)) - 2048);
				p.b = 16'(int'($urandom_range(0, 4095)) - 2048);
				p.c = 16'(int'($urandom_range(0, 4095)) - 2048);
				p.d = 16'(-int'($urandom_range(0, 32768)));
			end
			default: begin
				p = {$urandom, $urandom};
				p.d = 16'(-int'($urandom_range(0, 8192)));
			end
		endcase
		return p;
	endfunction

	function automatic logic [fpsc_pkg::PLANE_W-1:0] rand_margin();
		logic [fpsc_pkg::PLANE_W-1:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: v[15:0] = 16'(int'($urandom_range(0, 511)) - 256);
			1: v[15:0] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: ;
		endcase
		return v;
	endfunction

	// the block is idle once nothing is owed and the pipeline has drained
	task automatic write_reg(input logic [fpsc_pkg::CFG_IDX_W-1:0] idx,
			input logic [fpsc_pkg::PLANE_W-1:0] data);
		s_axis_tvalid <= 1'b0;
		while (inside_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx < fpsc_pkg::NUM_PLANES)
			plane_regs[idx] = data;
		else if (idx == fpsc_pkg::REG_MARGIN)
			margin_reg = data[fpsc_pkg::MARGIN_W-1:0];
	endtask

	task automatic send_query(input row_t row);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, row.r, row.z, row.y, row.x};
		s_axis_tuser <= row.cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		inside_due.push_back(row.known ? row.want
			: predict_inside(row.cmd, row.x, row.y, row.z, row.r));
	endtask

	always @(posedge clk) begin : result_check
		bit want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (inside_due.size() == 0) begin
				report_mismatch("result with no query pending");
			end else begin
				want = inside_due.pop_front();
				if (m_axis_tdata[0] !== want)
					report_mismatch($sformatf("inside_res %b, expected %b",
						m_axis_tdata[0], want));
			end
		end
		m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == MAX_CYCLES) begin
			$display("FAIL frustum_point_sphere_cull_core");
			$finish;
		end
	end

	initial begin
		row_t row;
		for (int i = 0; i < fpsc_pkg::NUM_PLANES; i++)
			plane_regs[i] = '0;

		// all-zero planes after reset: every query inside
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, -32768, 32767, -32768, 32767, 1, 1));
		steps.push_back(query_row(fpsc_pkg::CMD_SPHERE, 32767, -32768, 32767, 0, 1, 1));
		// negative margin rejects points even at zero distance; radius ignored
		steps.push_back(cfg_row(fpsc_pkg::REG_MARGIN, 64'hFFFF_FFFF_FFFF_FFFF));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, 0, 0, 0, 32767, 1, 0));
		steps.push_back(query_row(fpsc_pkg::CMD_SPHERE, 0, 0, 0, 0, 1, 1));
		// unknown index must not touch the margin
		steps.push_back(cfg_row(REG_UNUSED, 64'h0000_0000_0000_0050));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, 1, -1, 1, 0, 1, 0));
		// upper data bits of the margin write are dropped
		steps.push_back(cfg_row(fpsc_pkg::REG_MARGIN, 64'hFFFF_FFFF_FFFF_0000));
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_NEAR, 64'h0010_0000_0000_0000));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, 0, 0, 0, 0, 1, 0));
		steps.push_back(query_row(fpsc_pkg::CMD_SPHERE, 0, 0, 0, 0, 1, 1));
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_NEAR, 64'h0));
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_FAR, 64'h0010_0000_0000_0000));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, 0, 0, 0, 0, 1, 1));
		steps.push_back(query_row(fpsc_pkg::CMD_SPHERE, 0, 0, 0, 16, 1, 1));
		steps.push_back(query_row(fpsc_pkg::CMD_SPHERE, 0, 0, 0, 15, 1, 0));
		// box of half-size 16 with unit (1.0) normals
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_RIGHT, 64'hFFF0_0000_0000_4000));
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_LEFT, 64'hFFF0_0000_0000_C000));
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_TOP, 64'hFFF0_0000_4000_0000));
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_BOTTOM, 64'hFFF0_0000_C000_0000));
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_NEAR, 64'hFFF0_C000_0000_0000));
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_FAR, 64'hFFF0_4000_0000_0000));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, 17, 0, 0, 0, 0, 0));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, -17, 0, 0, 0, 0, 0));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, 0, 16, 0, 0, 0, 0));
		steps.push_back(query_row(fpsc_pkg::CMD_SPHERE, 0, -40, 0, 24, 0, 0));
		steps.push_back(query_row(fpsc_pkg::CMD_SPHERE, 0, 0, 20, 3, 0, 0));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, 0, 0, -20, 0, 0, 0));
		// extreme coefficients and margins
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_RIGHT, 64'h8000_8000_7FFF_8000));
		steps.push_back(cfg_row(fpsc_pkg::REG_PLANE_LEFT, 64'h7FFF_7FFF_8000_7FFF));
		steps.push_back(cfg_row(fpsc_pkg::REG_MARGIN, 64'h0000_0000_0000_7FFF));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, -32768, 32767, -32768, 0, 0, 0));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, 32767, -32768, 32767, 0, 0, 0));
		steps.push_back(cfg_row(fpsc_pkg::REG_MARGIN, 64'h0000_0000_0000_8000));
		steps.push_back(query_row(fpsc_pkg::CMD_SPHERE, 32767, 32767, 32767, 32767, 0, 0));
		steps.push_back(query_row(fpsc_pkg::CMD_SPHERE, -32768, -32768, -32768, 0, 0, 0));
		steps.push_back(query_row(fpsc_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].kind == ROW_CFG)
				write_reg(steps[i].idx, steps[i].data);
			else
				send_query(steps[i]);
		end

		for (int phase = 0; phase < 3; phase++) begin
			src_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 46 : 0;
			snk_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 15 : 0;
			for (int blk = 0; blk < BLOCKS; blk++) begin
				for (int idx = 0; idx < fpsc_pkg::NUM_PLANES; idx++)
					write_reg(3'(idx), rand_plane());
				write_reg(fpsc_pkg::REG_MARGIN, rand_margin());
				if ($urandom_range(0, 2) == 0)
					write_reg(REG_UNUSED, {$urandom, $urandom});
				for (int n = 0; n < BLOCK_LEN; n++) begin
					row = query_row(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
						rand_coord(), $urandom_range(0, 1) ? 15'($urandom)
						: 15'($urandom_range(0, 255)), 0, 0);
					send_query(row);
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		while (inside_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE * 2) @(posedge clk);
		if (errors == 0)
			$display("PASS frustum_point_sphere_cull_core");
		else
			$display("FAIL frustum_point_sphere_cull_core");
		$finish;
	end

endmodule

@@ files.f @@
hdl/fpsc_pkg.sv
hdl/fpsc_cfg_regs.sv
hdl/fpsc_plane_lane.sv
hdl/frustum_point_sphere_cull_core.sv
hdl/fpsc_checker.sv
tb/sv/testbench.sv
